// ----- rtl/lpht_pkg.sv -----
// Shared types and codes for the linear probe hash table unit.
package lpht_pkg;

  // Request codes (req_type field).
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_REPLACED = 3'd1;
  localparam logic [2:0] ST_FOUND    = 3'd2;
  localparam logic [2:0] ST_MISSING  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int ENTRY_W = 1 + KEY_W + VAL_W;  // {used, key, value}

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_PROBE,
    S_ACT
  } state_t;

  typedef enum logic [1:0] {
    HIT_EMPTY,
    HIT_MATCH,
    HIT_FULL
  } hit_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SET,
    WR_DEL,
    WR_CLR
  } wr_t;

  typedef struct packed {
    logic       load;
    logic       mod_start;
    logic       probe_start;
    logic       probing;
    wr_t        wr;
    logic       out_load;
    logic [2:0] status;
    logic       ret_value;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       probe_done;
    hit_t       hit;
    logic [1:0] req;
  } dp_sts_t;

endpackage

// ----- rtl/lpht_mod.sv -----
// Home slot: key mod SLOTS, low bits (pow2) or reciprocal multiply, one correction.
module lpht_mod #(
  parameter int SLOTS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lpht_pkg::KEY_W-1:0] key,
  output logic                       done,
  output logic [$clog2(SLOTS)-1:0]   home
);
  import lpht_pkg::*;

  localparam int IDXW = $clog2(SLOTS);
  localparam bit POW2 = (SLOTS == (1 << IDXW));
  localparam int PW   = 2 * KEY_W;
  // floor(2^32 / SLOTS): the quotient estimate is exact or one short
  localparam logic [KEY_W-1:0] RECIP   = KEY_W'((PW'(1) << KEY_W) / PW'(SLOTS));
  localparam logic [KEY_W-1:0] SLOTS_K = KEY_W'(SLOTS);

  logic [2:0]       stg_r, stg_nxt;   // product, multiply-back, correction
  logic             done_r, done_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [PW-1:0]    prod_r;
  logic [KEY_W-1:0] raw_r;
  logic [IDXW-1:0]  rem_r, rem_nxt;
  logic [KEY_W-1:0] quot;

  assign quot = prod_r[PW-1:KEY_W];

  always_comb begin
    stg_nxt  = {stg_r[1:0], 1'b0};
    done_nxt = stg_r[2];
    key_nxt  = key_r;
    rem_nxt  = rem_r;
    if (stg_r[2]) begin
      // raw remainder is below 2*SLOTS: one subtract finishes it
      rem_nxt = (raw_r >= SLOTS_K) ? IDXW'(raw_r - SLOTS_K) : IDXW'(raw_r);
    end
    if (start) begin
      key_nxt = key;
      if (POW2) begin
        rem_nxt  = key[IDXW-1:0];
        done_nxt = 1'b1;
      end else begin
        stg_nxt[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r  <= '0;
      done_r <= 1'b0;
    end else begin
      stg_r  <= stg_nxt;
      done_r <= done_nxt;
    end
  end

  // Product and multiply-back run every cycle; stg_r marks when they hold this key.
  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    rem_r  <= rem_nxt;
    prod_r <= PW'(key_r) * PW'(RECIP);
    raw_r  <= key_r - quot * SLOTS_K;
  end

  assign done = done_r;
  assign home = rem_r;

endmodule

// ----- rtl/lpht_dp.sv -----
// Datapath: slot memory, probe pointer, hit capture and result registers.
module lpht_dp #(
  parameter int SLOTS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lpht_pkg::ctrl_cmd_t        cmd,
  output lpht_pkg::dp_sts_t          sts,
  input  logic [1:0]                 in_req_type,
  input  logic [lpht_pkg::KEY_W-1:0] in_key,
  input  logic [lpht_pkg::VAL_W-1:0] in_value,
  input  logic [$clog2(SLOTS)-1:0]   home,
  output logic [2:0]                 out_status,
  output logic [lpht_pkg::VAL_W-1:0] out_read_value
);
  import lpht_pkg::*;

  localparam int IDXW = $clog2(SLOTS);
  localparam int CNTW = $clog2(SLOTS + 1);

  logic [ENTRY_W-1:0] slot_mem [SLOTS];

  logic [1:0]       req_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] value_r;

  logic [IDXW-1:0]  clr_r, clr_nxt;
  logic [IDXW-1:0]  pos_r, pos_nxt;
  logic [CNTW-1:0]  iss_cnt_r, iss_cnt_nxt;
  logic [IDXW-1:0]  chk_pos_r;
  logic [CNTW-1:0]  chk_cnt_r, chk_cnt_nxt;
  logic             q_vld_r, q_vld_nxt;
  logic [ENTRY_W-1:0] q_r;

  hit_t             hit_r;
  logic [IDXW-1:0]  hit_pos_r;
  logic [VAL_W-1:0] hit_val_r;

  logic [2:0]       out_status_r;
  logic [VAL_W-1:0] out_read_value_r;

  logic             q_used, q_match, q_last, stop, rd_en;
  hit_t             hit_now;
  logic             wr_en;
  logic [IDXW-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  // Check of the entry read last cycle.
  assign q_used  = q_r[ENTRY_W-1];
  assign q_match = (q_r[KEY_W+VAL_W-1:VAL_W] == key_r);
  assign q_last  = (chk_cnt_r == CNTW'(SLOTS - 1));
  assign stop    = cmd.probing && q_vld_r && (!q_used || q_match || q_last);
  assign rd_en   = cmd.probing && !stop && (iss_cnt_r != CNTW'(SLOTS));

  always_comb begin
    if (!q_used) begin
      hit_now = HIT_EMPTY;
    end else if (q_match) begin
      hit_now = HIT_MATCH;
    end else begin
      hit_now = HIT_FULL;
    end
  end

  always_comb begin
    pos_nxt     = pos_r;
    iss_cnt_nxt = iss_cnt_r;
    chk_cnt_nxt = chk_cnt_r;
    q_vld_nxt   = rd_en;
    if (cmd.probe_start) begin
      pos_nxt     = home;
      iss_cnt_nxt = '0;
      chk_cnt_nxt = '0;
    end else begin
      if (rd_en) begin
        pos_nxt     = (pos_r == IDXW'(SLOTS - 1)) ? '0 : pos_r + IDXW'(1);
        iss_cnt_nxt = iss_cnt_r + CNTW'(1);
      end
      if (cmd.probing && q_vld_r) begin
        chk_cnt_nxt = chk_cnt_r + CNTW'(1);
      end
    end
  end

  assign clr_nxt = (cmd.wr == WR_CLR) ? clr_r + IDXW'(1) : clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= '0;
      q_vld_r   <= 1'b0;
      iss_cnt_r <= '0;
      chk_cnt_r <= '0;
    end else begin
      clr_r     <= clr_nxt;
      q_vld_r   <= q_vld_nxt;
      iss_cnt_r <= iss_cnt_nxt;
      chk_cnt_r <= chk_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (rd_en) begin
      chk_pos_r <= pos_r;
    end
    if (cmd.load) begin
      req_r   <= in_req_type;
      key_r   <= in_key;
      value_r <= in_value;
    end
    if (stop) begin
      hit_r     <= hit_now;
      hit_pos_r <= chk_pos_r;
      hit_val_r <= q_r[VAL_W-1:0];
    end
    if (cmd.out_load) begin
      out_status_r     <= cmd.status;
      out_read_value_r <= cmd.ret_value ? hit_val_r : '0;
    end
  end

  // Slot memory: one write port, one registered read port.
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = hit_pos_r;
    wr_data = {1'b1, key_r, value_r};
    case (cmd.wr)
      WR_SET: wr_data = {1'b1, key_r, value_r};
      WR_DEL: wr_data = {1'b0, key_r, hit_val_r};
      WR_CLR: begin
        wr_addr = clr_r;
        wr_data = '0;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= slot_mem[pos_r];
    end
  end

  assign sts.clr_last   = (clr_r == IDXW'(SLOTS - 1));
  assign sts.probe_done = stop;
  assign sts.hit        = hit_r;
  assign sts.req        = req_r;

  assign out_status     = out_status_r;
  assign out_read_value = out_read_value_r;

endmodule

// ----- rtl/lpht_ctrl.sv -----
// Controller: clear pass, request sequencing, result decision and out_valid.
module lpht_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_req_type,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic                mod_done,
  input  lpht_pkg::dp_sts_t   sts,
  output lpht_pkg::ctrl_cmd_t cmd
);
  import lpht_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   known_req;

  assign out_free  = !out_valid_r || out_ready;
  assign known_req = (in_req_type inside {REQ_INSERT, REQ_SEARCH, REQ_REMOVE});

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = known_req ? S_MOD : S_ACT;
        end
      end
      S_MOD:   if (mod_done) state_nxt = S_PROBE;
      S_PROBE: if (sts.probe_done) state_nxt = S_ACT;
      S_ACT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd           = '0;
    cmd.wr        = WR_NONE;
    cmd.status    = ST_MISSING;
    in_ready      = 1'b0;
    case (state_r)
      S_CLEAR: cmd.wr = WR_CLR;
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load      = in_valid;
        cmd.mod_start = in_valid && known_req;
      end
      S_MOD:   cmd.probe_start = mod_done;
      S_PROBE: cmd.probing = 1'b1;
      S_ACT: begin
        cmd.out_load = out_free;
        case (sts.req)
          REQ_INSERT: begin
            case (sts.hit)
              HIT_MATCH: begin
                cmd.status = ST_REPLACED;
                cmd.wr     = out_free ? WR_SET : WR_NONE;
              end
              HIT_EMPTY: begin
                cmd.status = ST_INSERTED;
                cmd.wr     = out_free ? WR_SET : WR_NONE;
              end
              default: cmd.status = ST_FULL;
            endcase
          end
          REQ_SEARCH: begin
            if (sts.hit == HIT_MATCH) begin
              cmd.status    = ST_FOUND;
              cmd.ret_value = 1'b1;
            end
          end
          REQ_REMOVE: begin
            if (sts.hit == HIT_MATCH) begin
              cmd.status = ST_FOUND;
              cmd.wr     = out_free ? WR_DEL : WR_NONE;
            end
          end
          default: cmd.status = ST_MISSING;
        endcase
      end
      default: cmd.wr = WR_NONE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/linear_probe_hash_table_unit.sv -----
// Linear probe hash table unit: top level joining controller, home slot unit and datapath.
//
// Key/value table of SLOTS entries with open addressing. A request's home
// slot is key mod SLOTS; probing then walks forward one slot at a time,
// wrapping, and stops at the first empty slot, the first slot holding the
// key, or after one full pass. Insert replaces a matching key's value or
// fills the first empty slot (status 4 when the pass finds neither);
// search returns the value or a miss; remove empties a matching slot.
// Request type 3 is answered with status 3 and no change.
// After reset the unit clears every slot of the slot memory and
// takes no request until that pass is over. One request is in work at a
// time. A request passes through: the accept in the idle state, then the home slot computation
// (the low key bits when SLOTS is a power of two, else reciprocal multiply,
// multiply-back, correction and handoff), then probing (the slot memory
// has one registered read port, so one slot is examined per cycle after
// the first read), then the memory write and the result register load,
// held until the output register is free.
// Request type 3 skips straight to the result.
// The result sits in an output register; a new request is accepted while
// it waits, and the next result holds until the previous one is taken.
module linear_probe_hash_table_unit #(
  parameter int SLOTS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_req_type,
  input  logic [lpht_pkg::KEY_W-1:0] in_key,
  input  logic [lpht_pkg::VAL_W-1:0] in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_status,
  output logic [lpht_pkg::VAL_W-1:0] out_read_value
);
  import lpht_pkg::*;

  localparam int IDXW = $clog2(SLOTS);

  ctrl_cmd_t       cmd;
  dp_sts_t         sts;
  logic            mod_done;
  logic [IDXW-1:0] home;

  // Sequencer: clear pass, request flow, result decision.
  lpht_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mod_done    (mod_done),
    .sts         (sts),
    .cmd         (cmd)
  );

  // Home slot: key mod SLOTS, started when a known request type is accepted.
  lpht_mod #(
    .SLOTS (SLOTS)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mod_start),
    .key   (in_key),
    .done  (mod_done),
    .home  (home)
  );

  // Slot memory, probe walk and result registers.
  lpht_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_req_type    (in_req_type),
    .in_key         (in_key),
    .in_value       (in_value),
    .home           (home),
    .out_status     (out_status),
    .out_read_value (out_read_value)
  );

endmodule
